// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, held off while in reset
`define PLG_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// implication from one cycle to the next
`define PLG_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== hw/rtl/plg_pkg.sv =====
// types, constants and control structs of the level governor
package plg_pkg;

   localparam int NUM_DOMAINS = 8;
   localparam int MAX_ENTRIES = 16;
   localparam int DOM_W       = 3;
   localparam int IDX_W       = 4;
   localparam int CNT_W       = 5;
   localparam int LVL_W       = 32;
   localparam int AGENT_W     = 5;
   localparam int TAB_DEPTH   = NUM_DOMAINS * MAX_ENTRIES;
   localparam int TAB_AW      = DOM_W + IDX_W;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_SET    = 2'd1,
      CMD_LIMITS = 2'd2,
      CMD_REPORT = 2'd3
   } plg_cmd_code_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_PARAM = 2'd1,
      STATUS_RANGE = 2'd2
   } plg_status_type;

   typedef enum logic [1:0] {
      PH_SET,
      PH_CHKMIN,
      PH_CHKMAX,
      PH_MOVE
   } plg_phase_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_PRIME,
      S_SCAN,
      S_CHECK,
      S_STORE,
      S_FINISH
   } plg_state_type;

   typedef struct packed {
      logic           capture;
      logic           load_entry;
      logic           report;
      logic           store_limits;
      logic           scan_prime;
      logic           scan_step;
      plg_phase_type  phase;
      logic           status_en;
      plg_status_type status;
      logic           set_req;
      logic           publish;
   } plg_ctl_type;

   typedef struct packed {
      plg_cmd_code_type cmd;
      logic             dom_bad;
      logic             idx_bad;
      logic             param_err;
      logic             unchanged;
      logic             nearest;
      logic             move;
      logic             empty;
      logic             scan_end;
      logic             hit;
      logic             in_range;
      logic             out_busy;
   } plg_stat_type;

endpackage

// ===== hw/rtl/plg_ram.sv =====
// generic single write port ram with registered read
module plg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/plg_ctrl.sv =====
// sequencing state machine of the level governor
module plg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  plg_pkg::plg_stat_type stat,
   output plg_pkg::plg_ctl_type  ctl
);

   plg_pkg::plg_state_type state_ff, state_in;
   plg_pkg::plg_phase_type phase_ff, phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= plg_pkg::S_IDLE;
         phase_ff <= plg_pkg::PH_SET;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   assign req_stall = (state_ff != plg_pkg::S_IDLE);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      ctl      = '0;
      ctl.phase  = phase_ff;
      ctl.status = plg_pkg::STATUS_OK;
      case (state_ff)
         plg_pkg::S_IDLE: begin
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in    = plg_pkg::S_DECODE;
            end
         end
         plg_pkg::S_DECODE: begin
            state_in = plg_pkg::S_FINISH;
            if (stat.dom_bad) begin
               ctl.status_en = 1'b1;
               ctl.status    = plg_pkg::STATUS_RANGE;
            end else begin
               case (stat.cmd)
                  plg_pkg::CMD_LOAD: begin
                     if (stat.idx_bad) begin
                        ctl.status_en = 1'b1;
                        ctl.status    = plg_pkg::STATUS_RANGE;
                     end else begin
                        ctl.load_entry = 1'b1;
                     end
                  end
                  plg_pkg::CMD_SET: begin
                     phase_in = plg_pkg::PH_SET;
                     state_in = plg_pkg::S_PRIME;
                  end
                  plg_pkg::CMD_LIMITS: begin
                     if (stat.param_err) begin
                        ctl.status_en = 1'b1;
                        ctl.status    = plg_pkg::STATUS_PARAM;
                     end else if (!stat.unchanged) begin
                        if (stat.nearest) begin
                           state_in = plg_pkg::S_STORE;
                        end else begin
                           phase_in = plg_pkg::PH_CHKMIN;
                           state_in = plg_pkg::S_PRIME;
                        end
                     end
                  end
                  default: begin
                     ctl.report = 1'b1;
                  end
               endcase
            end
         end
         plg_pkg::S_PRIME: begin
            ctl.scan_prime = 1'b1;
            state_in = stat.empty ? plg_pkg::S_CHECK : plg_pkg::S_SCAN;
         end
         plg_pkg::S_SCAN: begin
            ctl.scan_step = 1'b1;
            if (stat.scan_end) begin
               state_in = plg_pkg::S_CHECK;
            end
         end
         plg_pkg::S_CHECK: begin
            state_in = plg_pkg::S_FINISH;
            case (phase_ff)
               plg_pkg::PH_SET: begin
                  if (stat.hit && stat.in_range) begin
                     ctl.set_req = 1'b1;
                  end else begin
                     ctl.status_en = 1'b1;
                     ctl.status    = plg_pkg::STATUS_RANGE;
                  end
               end
               plg_pkg::PH_CHKMIN: begin
                  if (stat.hit) begin
                     phase_in = plg_pkg::PH_CHKMAX;
                     state_in = plg_pkg::S_PRIME;
                  end else begin
                     ctl.status_en = 1'b1;
                     ctl.status    = plg_pkg::STATUS_RANGE;
                  end
               end
               plg_pkg::PH_CHKMAX: begin
                  if (stat.hit) begin
                     state_in = plg_pkg::S_STORE;
                  end else begin
                     ctl.status_en = 1'b1;
                     ctl.status    = plg_pkg::STATUS_RANGE;
                  end
               end
               default: begin
                  if (stat.hit) begin
                     ctl.set_req = 1'b1;
                  end else begin
                     ctl.status_en = 1'b1;
                     ctl.status    = plg_pkg::STATUS_RANGE;
                  end
               end
            endcase
         end
         plg_pkg::S_STORE: begin
            ctl.store_limits = 1'b1;
            if (stat.move) begin
               phase_in = plg_pkg::PH_MOVE;
               state_in = plg_pkg::S_PRIME;
            end else begin
               state_in = plg_pkg::S_FINISH;
            end
         end
         plg_pkg::S_FINISH: begin
            if (!stat.out_busy) begin
               ctl.publish = 1'b1;
               state_in    = plg_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = plg_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/plg_datapath.sv =====
// per-domain state, table scan and result register of the level governor
module plg_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic                          csr_approximate_mode,
   input  logic [1:0]                    req_cmd,
   input  logic [plg_pkg::DOM_W-1:0]     req_domain,
   input  logic [plg_pkg::AGENT_W-1:0]   req_agent,
   input  logic [plg_pkg::IDX_W-1:0]     req_entry_index,
   input  logic                          req_last_entry,
   input  logic [plg_pkg::LVL_W-1:0]     req_level,
   input  logic [plg_pkg::LVL_W-1:0]     req_limit_min,
   input  logic [plg_pkg::LVL_W-1:0]     req_limit_ceiling,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_dvfs_request,
   output logic [plg_pkg::LVL_W-1:0]     rsp_dvfs_level,
   output logic [plg_pkg::AGENT_W-1:0]   rsp_dvfs_agent,
   output logic [plg_pkg::DOM_W-1:0]     rsp_dvfs_domain,
   output logic                          rsp_limits_notify,
   output logic [plg_pkg::LVL_W-1:0]     rsp_notify_min,
   output logic [plg_pkg::LVL_W-1:0]     rsp_notify_max,
   input  plg_pkg::plg_ctl_type          ctl,
   output plg_pkg::plg_stat_type         stat
);

   // captured word
   plg_pkg::plg_cmd_code_type        cmd_ff;
   logic [plg_pkg::DOM_W-1:0]        dom_ff;
   logic [plg_pkg::AGENT_W-1:0]      agent_ff;
   logic [plg_pkg::IDX_W-1:0]        eidx_ff;
   logic                             last_ff;
   logic [plg_pkg::LVL_W-1:0]        lvl_ff, lmin_ff, lmax_ff;

   // per-domain state
   logic [plg_pkg::CNT_W-1:0] count_ff [plg_pkg::NUM_DOMAINS];
   logic [plg_pkg::LVL_W-1:0] min_ff   [plg_pkg::NUM_DOMAINS];
   logic [plg_pkg::LVL_W-1:0] max_ff   [plg_pkg::NUM_DOMAINS];
   logic [plg_pkg::LVL_W-1:0] cur_ff   [plg_pkg::NUM_DOMAINS];
   logic                      mode_ff;

   // scan
   logic [plg_pkg::IDX_W-1:0] sidx_ff;
   logic [plg_pkg::LVL_W-1:0] prev_ff, found_ff;
   logic                      hit_ff;

   // result being built
   plg_pkg::plg_status_type   res_status_ff;
   logic                      res_req_ff, res_notify_ff;
   logic [plg_pkg::LVL_W-1:0] res_level_ff;

   // output word
   logic                      rsp_valid_ff;
   logic [1:0]                rsp_status_ff;
   logic                      rsp_req_ff, rsp_notify_ff;
   logic [plg_pkg::LVL_W-1:0] rsp_level_ff, rsp_min_ff, rsp_max_ff;
   logic [plg_pkg::AGENT_W-1:0] rsp_agent_ff;
   logic [plg_pkg::DOM_W-1:0] rsp_dom_ff;

   logic [plg_pkg::LVL_W-1:0]  cur_lvl, dmin, dmax, cap, want, needle, rdata, v;
   logic [plg_pkg::CNT_W-1:0]  n;
   logic                       nearest, v_hit, v_last, scan_end;
   logic [plg_pkg::IDX_W-1:0]  rd_idx;
   logic [plg_pkg::TAB_AW-1:0] rd_addr, wr_addr;

   assign cur_lvl = cur_ff[dom_ff];
   assign dmin    = min_ff[dom_ff];
   assign dmax    = max_ff[dom_ff];
   assign cap     = dmax;
   assign n       = count_ff[dom_ff];
   assign needle  = (cur_lvl < lmin_ff) ? lmin_ff : lmax_ff;

   always_comb begin
      nearest = mode_ff;
      want    = lvl_ff;
      case (ctl.phase)
         plg_pkg::PH_SET: begin
            want = lvl_ff;
         end
         plg_pkg::PH_CHKMIN: begin
            nearest = 1'b0;
            want    = lmin_ff;
         end
         plg_pkg::PH_CHKMAX: begin
            nearest = 1'b0;
            want    = lmax_ff;
         end
         default: begin
            want = needle;
         end
      endcase
   end

   assign rd_idx  = ctl.scan_prime ? '0 : sidx_ff + 1'b1;
   assign rd_addr = {dom_ff, rd_idx};
   assign wr_addr = {dom_ff, eidx_ff};

   plg_ram #(
      .WIDTH (plg_pkg::LVL_W),
      .DEPTH (plg_pkg::TAB_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ctl.load_entry),
      .wr_addr (wr_addr),
      .wr_data (lvl_ff),
      .rd_addr (rd_addr),
      .rd_data (rdata)
   );

   assign v        = rdata;
   assign v_hit    = nearest ? !((v < want) && (v < cap)) : (v == want);
   assign v_last   = ({1'b0, sidx_ff} + 1'b1) == n;
   assign scan_end = v_hit || v_last;

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff   <= plg_pkg::plg_cmd_code_type'(req_cmd);
         dom_ff   <= req_domain;
         agent_ff <= req_agent;
         eidx_ff  <= req_entry_index;
         last_ff  <= req_last_entry;
         lvl_ff   <= req_level;
         lmin_ff  <= req_limit_min;
         lmax_ff  <= req_limit_ceiling;
      end
      if (ctl.scan_prime) begin
         sidx_ff <= '0;
         hit_ff  <= 1'b0;
      end else if (ctl.scan_step) begin
         if (scan_end) begin
            if (v_hit) begin
               hit_ff   <= 1'b1;
               found_ff <= ((v > cap) && (sidx_ff != '0)) ? prev_ff : v;
            end else begin
               hit_ff   <= nearest;
               found_ff <= v;
            end
         end else begin
            sidx_ff <= sidx_ff + 1'b1;
            prev_ff <= v;
         end
      end
      if (ctl.capture) begin
         res_status_ff <= plg_pkg::STATUS_OK;
         res_req_ff    <= 1'b0;
         res_notify_ff <= 1'b0;
      end else begin
         if (ctl.status_en) begin
            res_status_ff <= ctl.status;
         end
         if (ctl.set_req) begin
            res_req_ff   <= 1'b1;
            res_level_ff <= found_ff;
         end
         if (ctl.store_limits) begin
            res_notify_ff <= 1'b1;
         end
      end
      if (ctl.publish) begin
         rsp_status_ff <= res_status_ff;
         rsp_req_ff    <= res_req_ff;
         rsp_level_ff  <= res_req_ff ? res_level_ff : '0;
         rsp_agent_ff  <= res_req_ff ? agent_ff : '0;
         rsp_dom_ff    <= dom_ff;
         rsp_notify_ff <= res_notify_ff;
         rsp_min_ff    <= res_notify_ff ? lmin_ff : '0;
         rsp_max_ff    <= res_notify_ff ? lmax_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < plg_pkg::NUM_DOMAINS; i++) begin
            count_ff[i] <= '0;
            min_ff[i]   <= '0;
            max_ff[i]   <= '0;
            cur_ff[i]   <= '0;
         end
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            mode_ff <= csr_approximate_mode;
         end
         if (ctl.load_entry) begin
            if (eidx_ff == '0) begin
               min_ff[dom_ff] <= lvl_ff;
            end
            if (last_ff) begin
               count_ff[dom_ff] <= {1'b0, eidx_ff} + 1'b1;
               max_ff[dom_ff]   <= lvl_ff;
            end
         end
         if (ctl.store_limits) begin
            min_ff[dom_ff] <= lmin_ff;
            max_ff[dom_ff] <= lmax_ff;
         end
         if (ctl.report) begin
            cur_ff[dom_ff] <= lvl_ff;
         end
         if (ctl.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      stat           = '0;
      stat.cmd       = cmd_ff;
      stat.dom_bad   = (plg_pkg::DOM_W + 1)'(dom_ff)
                       >= (plg_pkg::DOM_W + 1)'(plg_pkg::NUM_DOMAINS);
      stat.idx_bad   = (plg_pkg::IDX_W + 1)'(eidx_ff)
                       >= (plg_pkg::IDX_W + 1)'(plg_pkg::MAX_ENTRIES);
      stat.param_err = lmin_ff > lmax_ff;
      stat.unchanged = (lmin_ff == dmin) && (lmax_ff == dmax);
      stat.nearest   = mode_ff;
      stat.move      = (cur_lvl < lmin_ff) || (cur_lvl > lmax_ff);
      stat.empty     = (n == '0);
      stat.scan_end  = scan_end;
      stat.hit       = hit_ff;
      stat.in_range  = (found_ff >= dmin) && (found_ff <= dmax);
      stat.out_busy  = rsp_valid_ff && rsp_stall;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_dvfs_request  = rsp_req_ff;
   assign rsp_dvfs_level    = rsp_level_ff;
   assign rsp_dvfs_agent    = rsp_agent_ff;
   assign rsp_dvfs_domain   = rsp_dom_ff;
   assign rsp_limits_notify = rsp_notify_ff;
   assign rsp_notify_min    = rsp_min_ff;
   assign rsp_notify_max    = rsp_max_ff;

endmodule

// ===== hw/rtl/perf_level_limit_governor.sv =====
// top level of the performance level governor
// One word is handled at a time. Load and report words go from decode
// straight to finish; set level primes, scans the table and checks the
// entry it found; set limits may run up to three table scans in exact
// mode and one in nearest mode. The scan reads the level table ram one
// entry a cycle. A finished result sits in the output register while the
// next word is accepted.
`include "assert_macros.svh"

module perf_level_limit_governor (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_approximate_mode,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_cmd,
   input  logic [plg_pkg::DOM_W-1:0]     req_domain,
   input  logic [plg_pkg::AGENT_W-1:0]   req_agent,
   input  logic [plg_pkg::IDX_W-1:0]     req_entry_index,
   input  logic                          req_last_entry,
   input  logic [plg_pkg::LVL_W-1:0]     req_level,
   input  logic [plg_pkg::LVL_W-1:0]     req_limit_min,
   input  logic [plg_pkg::LVL_W-1:0]     req_limit_ceiling,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_dvfs_request,
   output logic [plg_pkg::LVL_W-1:0]     rsp_dvfs_level,
   output logic [plg_pkg::AGENT_W-1:0]   rsp_dvfs_agent,
   output logic [plg_pkg::DOM_W-1:0]     rsp_dvfs_domain,
   output logic                          rsp_limits_notify,
   output logic [plg_pkg::LVL_W-1:0]     rsp_notify_min,
   output logic [plg_pkg::LVL_W-1:0]     rsp_notify_max
);

   plg_pkg::plg_ctl_type  ctl;
   plg_pkg::plg_stat_type stat;

   assign csr_ready = 1'b1;

   plg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .ctl       (ctl)
   );

   plg_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_approximate_mode (csr_approximate_mode),
      .req_cmd              (req_cmd),
      .req_domain           (req_domain),
      .req_agent            (req_agent),
      .req_entry_index      (req_entry_index),
      .req_last_entry       (req_last_entry),
      .req_level            (req_level),
      .req_limit_min        (req_limit_min),
      .req_limit_ceiling    (req_limit_ceiling),
      .rsp_stall            (rsp_stall),
      .rsp_valid            (rsp_valid),
      .rsp_status           (rsp_status),
      .rsp_dvfs_request     (rsp_dvfs_request),
      .rsp_dvfs_level       (rsp_dvfs_level),
      .rsp_dvfs_agent       (rsp_dvfs_agent),
      .rsp_dvfs_domain      (rsp_dvfs_domain),
      .rsp_limits_notify    (rsp_limits_notify),
      .rsp_notify_min       (rsp_notify_min),
      .rsp_notify_max       (rsp_notify_max),
      .ctl                  (ctl),
      .stat                 (stat)
   );

   `PLG_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "accepted word not held busy")
   `PLG_ASSERT(a_req_ok, rsp_valid && rsp_dvfs_request |-> rsp_status == plg_pkg::STATUS_OK, "request with error status")
   `PLG_ASSERT(a_notify_order, rsp_valid && rsp_limits_notify |-> rsp_notify_min <= rsp_notify_max, "announced limits out of order")
   `PLG_ASSERT(a_no_req_zero, rsp_valid && !rsp_dvfs_request |-> rsp_dvfs_level == '0 && rsp_dvfs_agent == '0, "stale request payload")

endmodule
